FILE: hdl/cldo_pkg.sv
package cldo_pkg;

   localparam int NUM_LDOS         = 7;
   localparam int NUM_SENSORS      = 4;
   localparam int NUM_SUPPLY_TYPES = 8;
   localparam int COUNT_WIDTH      = 16;

   localparam int LDO_IDX_W = (NUM_LDOS > 1) ? $clog2(NUM_LDOS) : 1;

   // Route codes and LDO numbering.
   localparam logic [2:0] LDO_DVDD1  = 3'd0;
   localparam logic [2:0] LDO_DVDD2  = 3'd1;
   localparam logic [2:0] LDO_AVDD1  = 3'd2;
   localparam logic [2:0] LDO_AVDD2  = 3'd3;
   localparam logic [2:0] LDO_VDDAF  = 3'd4;
   localparam logic [2:0] LDO_VDDOIS = 3'd5;
   localparam logic [2:0] LDO_VDDIO  = 3'd6;
   localparam logic [2:0] NO_ROUTE   = 3'd7;

   localparam logic [2:0] SENSOR_MAIN  = 3'd0;
   localparam logic [2:0] SENSOR_FRONT = 3'd1;
   localparam logic [2:0] SENSOR_WIDE  = 3'd2;
   localparam logic [2:0] SENSOR_TELE  = 3'd3;

   localparam logic [2:0] SUPPLY_VANA = 3'd1;
   localparam logic [2:0] SUPPLY_VDIG = 3'd2;
   localparam logic [2:0] SUPPLY_VIO  = 3'd3;
   localparam logic [2:0] SUPPLY_VAF  = 3'd4;

   localparam logic CMD_ENABLE  = 1'b0;
   localparam logic CMD_DISABLE = 1'b1;

   localparam logic [1:0] CHIP_TYPE_0 = 2'd0;
   localparam logic [1:0] CHIP_TYPE_1 = 2'd1;
   localparam logic [1:0] CHIP_TYPE_2 = 2'd2;
   localparam logic [1:0] CHIP_TYPE_3 = 2'd3;

   localparam logic [1:0] REG_CHIP_TYPE   = 2'd0;
   localparam logic [1:0] REG_VOUT_BASE   = 2'd1;
   localparam logic [1:0] REG_ENABLE_ADDR = 2'd2;

   localparam int CSR_ADDR_W = 4;

   localparam logic [7:0] ENABLE_TYPE0_BIT = 8'h80;

   // Voltage limits in microvolts.
   localparam logic [22:0] VMIN_ALLOWED     = 23'd600000;
   localparam logic [22:0] FLOOR_T0_CORE    = 23'd496000;
   localparam logic [22:0] FLOOR_T0_ANALOG  = 23'd1504000;
   localparam logic [22:0] FLOOR_T1_CORE    = 23'd600000;
   localparam logic [22:0] FLOOR_T1_ANALOG  = 23'd1200000;
   localparam logic [22:0] FLOOR_T2_CORE    = 23'd800000;
   localparam logic [22:0] FLOOR_T2_ANALOG  = 23'd1500000;
   localparam logic [22:0] T2_ANALOG_BIAS   = 23'd4000;

   // Reciprocal constants for dividing a 23-bit microvolt value by a fixed step.
   localparam int RECIP_SHIFT = 37;
   localparam int RECIP_W     = 25;
   localparam int PROD_W      = 23 + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam longint unsigned DIV_SCALE = 64'd1 << RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_6000  = RECIP_W'((DIV_SCALE + 64'd5999) / 64'd6000);
   localparam logic [RECIP_W-1:0] RECIP_8000  = RECIP_W'((DIV_SCALE + 64'd7999) / 64'd8000);
   localparam logic [RECIP_W-1:0] RECIP_10000 = RECIP_W'((DIV_SCALE + 64'd9999) / 64'd10000);

   // Offsets subtracted from the quotient to form the output code.
   localparam logic [7:0] SUB_T0_CORE   = 8'd62;
   localparam logic [7:0] SUB_T0_ANALOG = 8'd188;
   localparam logic [7:0] SUB_T1_CORE   = 8'd100;
   localparam logic [7:0] SUB_T1_ANALOG = 8'd120;
   localparam logic [7:0] SUB_T2_CORE   = 8'd1;
   localparam logic [7:0] SUB_T2_ANALOG = 8'd171;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_PARAM   = 3'd1,
      ST_NO_ROUTE    = 3'd2,
      ST_UNDERFLOW   = 3'd3,
      ST_BELOW_FLOOR = 3'd4
   } status_type;

   typedef struct packed {
      logic        cmd;
      logic [2:0]  sensor_id;
      logic [2:0]  supply_type;
      logic [22:0] min_voltage_uv;
      logic [22:0] max_voltage_uv;
   } req_type;

   typedef struct packed {
      logic [1:0] chip_type;
      logic [7:0] vout_base_addr;
      logic [7:0] enable_reg_addr;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic        write_valid;
      logic [7:0]  reg_addr;
      logic [7:0]  reg_data;
      logic [15:0] ref_count;
      logic        last;
   } result_type;

   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;
   } pair_type;

   function automatic logic [2:0] route_lookup(input logic [2:0] sensor,
                                               input logic [2:0] supply);
      logic [2:0] ldo;
      ldo = NO_ROUTE;
      case (sensor)
         SENSOR_MAIN: begin
            case (supply)
               SUPPLY_VANA: ldo = LDO_AVDD1;
               SUPPLY_VDIG: ldo = LDO_DVDD2;
               SUPPLY_VIO:  ldo = LDO_VDDIO;
               SUPPLY_VAF:  ldo = LDO_VDDAF;
               default:     ldo = NO_ROUTE;
            endcase
         end
         SENSOR_FRONT: begin
            case (supply)
               SUPPLY_VANA: ldo = LDO_AVDD1;
               SUPPLY_VDIG: ldo = LDO_DVDD1;
               SUPPLY_VIO:  ldo = LDO_VDDIO;
               default:     ldo = NO_ROUTE;
            endcase
         end
         SENSOR_WIDE: begin
            case (supply)
               SUPPLY_VANA: ldo = LDO_AVDD2;
               SUPPLY_VDIG: ldo = LDO_DVDD1;
               SUPPLY_VIO:  ldo = LDO_VDDIO;
               default:     ldo = NO_ROUTE;
            endcase
         end
         SENSOR_TELE: begin
            case (supply)
               SUPPLY_VANA: ldo = LDO_VDDOIS;
               SUPPLY_VDIG: ldo = LDO_DVDD1;
               SUPPLY_VIO:  ldo = LDO_VDDIO;
               SUPPLY_VAF:  ldo = LDO_VDDAF;
               default:     ldo = NO_ROUTE;
            endcase
         end
         default: ldo = NO_ROUTE;
      endcase
      return ldo;
   endfunction

endpackage

FILE: hdl/cldo_req_if.sv
interface cldo_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [2:0]  sensor_id;
   logic [2:0]  supply_type;
   logic [22:0] min_voltage_uv;
   logic [22:0] max_voltage_uv;

   modport source (
      output valid, cmd, sensor_id, supply_type, min_voltage_uv, max_voltage_uv,
      input  ready
   );
   modport sink (
      input  valid, cmd, sensor_id, supply_type, min_voltage_uv, max_voltage_uv,
      output ready
   );
endinterface

FILE: hdl/cldo_rsp_if.sv
interface cldo_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        write_valid;
   logic [7:0]  reg_addr;
   logic [7:0]  reg_data;
   logic [15:0] ref_count;
   logic        last;

   modport source (
      output valid, status, write_valid, reg_addr, reg_data, ref_count, last,
      input  ready
   );
   modport sink (
      input  valid, status, write_valid, reg_addr, reg_data, ref_count, last,
      output ready
   );
endinterface

FILE: hdl/cldo_engine.sv
module cldo_engine
   import cldo_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  req_type  item,
   input  cfg_type  cfg,
   output pair_type pair
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] counts_ff [NUM_LDOS];
   logic [7:0]             shadow_ff;
   logic [7:0]             shadow_in;
   logic                   count_we;
   logic [COUNT_WIDTH-1:0] count_in;

   logic                 bad;
   logic                 no_route;
   logic [2:0]           route;
   logic [LDO_IDX_W-1:0] ldo;
   logic [COUNT_WIDTH-1:0] cnt;
   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic [COUNT_WIDTH-1:0] cnt_dec;
   logic [7:0]           ldo_bit;
   logic                 core;

   logic [22:0]          floor_uv;
   logic [RECIP_W-1:0]   recip;
   logic [7:0]           sub;
   logic                 use_bias;
   logic [22:0]          dividend;
   logic [PROD_W-1:0]    product;
   logic [QUOT_W-1:0]    quot;
   logic [7:0]           code;
   logic                 above_floor;

   assign route    = route_lookup(item.sensor_id, item.supply_type);
   assign no_route = {1'b0, route} >= 4'(NUM_LDOS);
   assign ldo      = route[LDO_IDX_W-1:0];
   assign cnt      = counts_ff[ldo];
   assign cnt_inc  = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
   assign cnt_dec  = cnt - 1'b1;
   assign ldo_bit  = 8'd1 << route;
   assign core     = route < LDO_AVDD1;

   always_comb begin
      bad = ({1'b0, item.sensor_id} >= 4'(NUM_SENSORS))
         || ({1'b0, item.supply_type} >= 4'(NUM_SUPPLY_TYPES));
      if (item.cmd == CMD_ENABLE) begin
         bad = bad || (item.min_voltage_uv < VMIN_ALLOWED)
            || (item.max_voltage_uv < VMIN_ALLOWED)
            || (item.min_voltage_uv > item.max_voltage_uv);
      end
   end

   // Each chip formula reduces to floor(uv / step_in_uv) minus a constant (type 2 analog
   // first subtracts a bias from uv), so one reciprocal multiply covers every case.
   always_comb begin
      use_bias = 1'b0;
      case (cfg.chip_type)
         CHIP_TYPE_1: begin
            floor_uv = core ? FLOOR_T1_CORE : FLOOR_T1_ANALOG;
            recip    = core ? RECIP_6000 : RECIP_10000;
            sub      = core ? SUB_T1_CORE : SUB_T1_ANALOG;
         end
         CHIP_TYPE_2: begin
            floor_uv = core ? FLOOR_T2_CORE : FLOOR_T2_ANALOG;
            recip    = RECIP_8000;
            sub      = core ? SUB_T2_CORE : SUB_T2_ANALOG;
            use_bias = !core;
         end
         default: begin
            floor_uv = core ? FLOOR_T0_CORE : FLOOR_T0_ANALOG;
            recip    = RECIP_8000;
            sub      = core ? SUB_T0_CORE : SUB_T0_ANALOG;
         end
      endcase
   end

   assign above_floor = item.min_voltage_uv >= floor_uv;
   assign dividend    = use_bias ? item.min_voltage_uv - T2_ANALOG_BIAS
                                 : item.min_voltage_uv;
   assign product     = PROD_W'(dividend) * PROD_W'(recip);
   assign quot        = product[PROD_W-1:RECIP_SHIFT];
   assign code        = quot[7:0] - sub;

   always_comb begin
      pair      = '0;
      shadow_in = shadow_ff;
      count_we  = 1'b0;
      count_in  = cnt;
      pair.first.last = 1'b1;
      if (bad) begin
         pair.first.status = ST_BAD_PARAM;
      end else if (no_route) begin
         pair.first.status = ST_NO_ROUTE;
      end else if (item.cmd == CMD_ENABLE) begin
         count_we = 1'b1;
         count_in = cnt_inc;
         pair.first.ref_count = 16'(cnt_inc);
         if (cnt == '0) begin
            shadow_in = shadow_ff | ldo_bit;
            if (cfg.chip_type != CHIP_TYPE_1 && cfg.chip_type != CHIP_TYPE_2) begin
               shadow_in = shadow_in | ENABLE_TYPE0_BIT;
            end
            pair.second.status      = ST_OK;
            pair.second.write_valid = 1'b1;
            pair.second.reg_addr    = cfg.enable_reg_addr;
            pair.second.reg_data    = shadow_in;
            pair.second.ref_count   = 16'(cnt_inc);
            pair.second.last        = 1'b1;
            if (above_floor) begin
               pair.two               = 1'b1;
               pair.first.write_valid = 1'b1;
               pair.first.reg_addr    = cfg.vout_base_addr + 8'(route);
               pair.first.reg_data    = code;
               pair.first.last        = 1'b0;
            end else begin
               pair.first        = pair.second;
               pair.first.status = ST_BELOW_FLOOR;
            end
         end
      end else if (cnt == '0) begin
         pair.first.status = ST_UNDERFLOW;
      end else begin
         count_we = 1'b1;
         count_in = cnt_dec;
         pair.first.ref_count = 16'(cnt_dec);
         if (cnt_dec == '0) begin
            shadow_in = shadow_ff & ~ldo_bit;
            pair.first.write_valid = 1'b1;
            pair.first.reg_addr    = cfg.enable_reg_addr;
            pair.first.reg_data    = shadow_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LDOS; i++) begin
            counts_ff[i] <= '0;
         end
         shadow_ff <= '0;
      end else if (fire) begin
         if (count_we) begin
            counts_ff[ldo] <= count_in;
         end
         shadow_ff <= shadow_in;
      end
   end

   // An LDO's enable bit is set exactly while its count is nonzero.
   for (genvar i = 0; i < NUM_LDOS && i < 7; i++) begin : g_shadow_chk
      a_shadow_tracks_count: assert property (@(posedge clock) disable iff (reset)
         shadow_ff[i] == (counts_ff[i] != '0))
         else $error("enable shadow bit out of step with reference count");
   end

endmodule

FILE: hdl/cldo_rsp_stage.sv
module cldo_rsp_stage
   import cldo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  pair_type   pair,
   output logic       room,
   cldo_rsp_if.source rsp
);

   pair_type   pair_ff;
   logic       pair_valid_ff;
   logic       idx_ff;
   logic       final_entry;
   logic       pop;
   result_type cur;

   assign final_entry = !pair_ff.two || idx_ff;
   assign pop         = pair_valid_ff && rsp.ready;
   assign room        = !pair_valid_ff || (pop && final_entry);
   assign cur         = idx_ff ? pair_ff.second : pair_ff.first;

   assign rsp.valid       = pair_valid_ff;
   assign rsp.status      = cur.status;
   assign rsp.write_valid = cur.write_valid;
   assign rsp.reg_addr    = cur.reg_addr;
   assign rsp.reg_data    = cur.reg_data;
   assign rsp.ref_count   = cur.ref_count;
   assign rsp.last        = cur.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         idx_ff        <= 1'b0;
      end else if (load) begin
         pair_valid_ff <= 1'b1;
         idx_ff        <= 1'b0;
      end else if (pop && final_entry) begin
         pair_valid_ff <= 1'b0;
         idx_ff        <= 1'b0;
      end else if (pop) begin
         idx_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pair_ff <= pair;
      end
   end

   a_second_only_in_pair: assert property (@(posedge clock) disable iff (reset)
      idx_ff |-> (pair_valid_ff && pair_ff.two))
      else $error("second entry selected without a two-result item");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (pop && !final_entry) |=> (rsp.valid && rsp.last))
      else $error("second result of a pair did not follow the first");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (pair_valid_ff && !rsp.ready) |-> !load)
      else $error("result register loaded while a result is stalled");

endmodule

FILE: hdl/camera_ldo_refcount_sequencer.sv
// Camera LDO reference-count sequencer. Requests are registered on acceptance
// and evaluated once the result register has room: the route lookup and the
// voltage code (one reciprocal multiply) are formed, the results are loaded into
// the result register and the count and enable-shadow updates are written. A
// request with one result can be accepted in every cycle while the result side
// is ready; a first enable with a voltage write holds the result register until
// both of its results are taken, since that register hands out one result per
// cycle while the result side is ready. Reset needs no clearing pass.
// Configuration registers lie at byte addresses 0 (chip_type), 4 (vout_base_addr)
// and 8 (enable_reg_addr).
module camera_ldo_refcount_sequencer
   import cldo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   cldo_req_if.sink              req_chan,
   cldo_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type  cfg_ff;
   req_type  item_ff;
   logic     item_valid_ff;
   logic     fire;
   logic     room;
   logic     csr_write;
   pair_type pair;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_paddr[CSR_ADDR_W-1:2])
            REG_CHIP_TYPE:   cfg_ff.chip_type       <= csr_pwdata[1:0];
            REG_VOUT_BASE:   cfg_ff.vout_base_addr  <= csr_pwdata[7:0];
            REG_ENABLE_ADDR: cfg_ff.enable_reg_addr <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_ADDR_W-1:2])
         REG_CHIP_TYPE:   csr_prdata = 32'(cfg_ff.chip_type);
         REG_VOUT_BASE:   csr_prdata = 32'(cfg_ff.vout_base_addr);
         REG_ENABLE_ADDR: csr_prdata = 32'(cfg_ff.enable_reg_addr);
         default:         csr_prdata = '0;
      endcase
   end

   assign fire           = item_valid_ff && room;
   assign req_chan.ready = !item_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.cmd            <= req_chan.cmd;
         item_ff.sensor_id      <= req_chan.sensor_id;
         item_ff.supply_type    <= req_chan.supply_type;
         item_ff.min_voltage_uv <= req_chan.min_voltage_uv;
         item_ff.max_voltage_uv <= req_chan.max_voltage_uv;
      end
   end

   cldo_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item_ff),
      .cfg   (cfg_ff),
      .pair  (pair)
   );

   cldo_rsp_stage u_rsp_stage (
      .clock (clock),
      .reset (reset),
      .load  (fire),
      .pair  (pair),
      .room  (room),
      .rsp   (rsp_chan)
   );

endmodule
